>>> rtl/satq_pkg.sv
// ----------------------------------------------------------------------------
// satq_pkg
// Types, constants and helpers shared by the sorted alarm timer queue.
// ----------------------------------------------------------------------------
package satq_pkg;

  localparam int TIME_W  = 32;
  localparam int DELAY_W = 31;
  localparam int TAG_W   = 16;

  localparam logic STATUS_FIRED  = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_POP
  } state_t;

  typedef struct packed {
    logic take;
    logic do_insert;
    logic do_pop;
    logic load_reject;
    logic load_fire;
    logic last;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic full;
    logic head_due;
    logic next_due;
    logic out_free;
  } dp_stat_t;

  // a strictly later than b, modulo 2^32
  function automatic logic later_than(input logic [TIME_W-1:0] a,
                                      input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[TIME_W-1];
  endfunction

endpackage

>>> rtl/satq_in_if.sv
// ----------------------------------------------------------------------------
// satq_in_if
// Request channel: tick or insert item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface satq_in_if import satq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [DELAY_W-1:0] delay_seconds;
  logic [TAG_W-1:0]   alarm_tag;

  modport source (output valid, mode, delay_seconds, alarm_tag, input ready);
  modport sink   (input valid, mode, delay_seconds, alarm_tag, output ready);
endinterface

>>> rtl/satq_out_if.sv
// ----------------------------------------------------------------------------
// satq_out_if
// Result channel: fired or rejected alarm item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface satq_out_if import satq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic [TAG_W-1:0]  fired_tag;
  logic [TIME_W-1:0] expiry_time;
  logic [TIME_W-1:0] current_time;
  logic              last;

  modport source (output valid, status, fired_tag, expiry_time, current_time, last,
                  input ready);
  modport sink   (input valid, status, fired_tag, expiry_time, current_time, last,
                  output ready);
endinterface

>>> rtl/satq_dp.sv
// ----------------------------------------------------------------------------
// satq_dp
// Datapath: seconds counter, sorted entry array with shift insert and head
// pop, and the result register.
// ----------------------------------------------------------------------------
module satq_dp import satq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic               in_mode,
  input  logic [DELAY_W-1:0] in_delay,
  input  logic [TAG_W-1:0]   in_tag,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_status,
  output logic [TAG_W-1:0]   out_tag,
  output logic [TIME_W-1:0]  out_expiry,
  output logic [TIME_W-1:0]  out_now,
  output logic               out_last
);

  localparam int KEEP_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);

  logic [TIME_W-1:0] now;
  logic [OCC_W-1:0]  occ;
  logic              mode_reg;
  logic [TIME_W-1:0] exp_reg;
  logic [KEEP_W-1:0] tag_reg;

  logic [TIME_W-1:0] exp_q [QUEUE_DEPTH];
  logic [KEEP_W-1:0] tag_q [QUEUE_DEPTH];

  logic [QUEUE_DEPTH-1:0] gt;
  logic [QUEUE_DEPTH-1:0] hit;
  logic [QUEUE_DEPTH-1:0] shift_up;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      gt[i]  = (OCC_W'(i) < occ) && later_than(exp_q[i], exp_reg);
      hit[i] = gt[i] || (OCC_W'(i) == occ);
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      shift_up[i] = |(hit & ((QUEUE_DEPTH'(1) << i) - QUEUE_DEPTH'(1)));
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_entry
    logic [TIME_W-1:0] up_exp;
    logic [KEEP_W-1:0] up_tag;
    logic [TIME_W-1:0] dn_exp;
    logic [KEEP_W-1:0] dn_tag;

    if (g == 0) begin : g_first
      assign up_exp = exp_reg;
      assign up_tag = tag_reg;
    end else begin : g_rest
      assign up_exp = exp_q[g-1];
      assign up_tag = tag_q[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign dn_exp = exp_q[g];
      assign dn_tag = tag_q[g];
    end else begin : g_body
      assign dn_exp = exp_q[g+1];
      assign dn_tag = tag_q[g+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.do_insert) begin
        if (shift_up[g]) begin
          exp_q[g] <= up_exp;
          tag_q[g] <= up_tag;
        end else if (hit[g]) begin
          exp_q[g] <= exp_reg;
          tag_q[g] <= tag_reg;
        end
      end else if (cmd.do_pop) begin
        exp_q[g] <= dn_exp;
        tag_q[g] <= dn_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now <= '0;
      occ <= '0;
    end else begin
      if (cmd.take && (in_mode == MODE_TICK)) begin
        now <= now + TIME_W'(1);
      end
      if (cmd.do_insert) begin
        occ <= occ + OCC_W'(1);
      end else if (cmd.do_pop) begin
        occ <= occ - OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mode_reg <= in_mode;
      exp_reg  <= now + TIME_W'(in_delay);
      tag_reg  <= in_tag[KEEP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_reject || cmd.load_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_reject) begin
      out_status <= STATUS_REJECT;
      out_tag    <= TAG_W'(tag_reg);
      out_expiry <= exp_reg;
      out_now    <= now;
      out_last   <= cmd.last;
    end else if (cmd.load_fire) begin
      out_status <= STATUS_FIRED;
      out_tag    <= TAG_W'(tag_q[0]);
      out_expiry <= exp_q[0];
      out_now    <= now;
      out_last   <= cmd.last;
    end
  end

  assign stat.mode     = mode_reg;
  assign stat.full     = (occ == OCC_W'(QUEUE_DEPTH));
  assign stat.head_due = (occ != '0) && !later_than(exp_q[0], now);
  assign stat.next_due = (occ > OCC_W'(1)) && !later_than(exp_q[1], now);
  assign stat.out_free = !out_valid || out_ready;

`ifndef SYNTH
  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(QUEUE_DEPTH))
    else $error("occupancy above depth");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_reject || cmd.load_fire) |-> (!out_valid || out_ready))
    else $error("result register overwritten");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.do_pop |=> (occ == $past(occ) - OCC_W'(1)))
    else $error("pop did not drop an entry");
  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    cmd.do_insert |-> (occ < OCC_W'(QUEUE_DEPTH)))
    else $error("insert into full queue");
`endif

endmodule

>>> rtl/satq_ctrl.sv
// ----------------------------------------------------------------------------
// satq_ctrl
// Controller: takes an item, runs insert or reject for an insert item, then pops
// due heads one per cycle while the result channel is free and marks the last result.
// ----------------------------------------------------------------------------
module satq_ctrl import satq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] n;

  logic can_pop;
  logic more;

  assign can_pop = stat.head_due && (n < CNT_W'(QUEUE_DEPTH));
  assign more    = stat.next_due && (n < CNT_W'(QUEUE_DEPTH - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_INSERT;
        end
      end
      ST_INSERT: begin
        if (stat.mode == MODE_TICK || !stat.full) begin
          state_next = ST_POP;
        end else if (stat.out_free) begin
          state_next = stat.head_due ? ST_POP : ST_IDLE;
        end
      end
      ST_POP: begin
        if (!can_pop) begin
          state_next = ST_IDLE;
        end else if (stat.out_free && !more) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_INSERT: begin
        if (stat.mode == MODE_INSERT) begin
          if (!stat.full) begin
            cmd.do_insert = 1'b1;
          end else if (stat.out_free) begin
            cmd.load_reject = 1'b1;
            cmd.last        = !stat.head_due;
          end
        end
      end
      ST_POP: begin
        if (can_pop && stat.out_free) begin
          cmd.load_fire = 1'b1;
          cmd.do_pop    = 1'b1;
          cmd.last      = !more;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      n     <= '0;
    end else begin
      state <= state_next;
      if (cmd.take) begin
        n <= '0;
      end else if (cmd.load_reject || cmd.load_fire) begin
        n <= n + CNT_W'(1);
      end
    end
  end

`ifndef SYNTH
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    n <= CNT_W'(QUEUE_DEPTH))
    else $error("more results than queue depth");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    ((cmd.load_reject || cmd.load_fire) && cmd.last) |=> (state == ST_IDLE))
    else $error("last result did not end the item");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> (state == ST_INSERT))
    else $error("taken item not processed");
`endif

endmodule

>>> rtl/sorted_alarm_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted_alarm_timer_queue
// Alarm queue sorted by wrap-aware expiry second, with a seconds counter.
// ----------------------------------------------------------------------------
// One item at a time. Each item passes through the controller sequence (take,
// insert or reject, pop check); the head pop shifts the sorted register array
// by one entry for each fired alarm. Cycles in which the result channel holds
// ready low while a result waits stall the sequence. A rejected insert gives
// its status result before any pops. No more than QUEUE_DEPTH results follow
// one item; later due alarms wait for the next item.
// ----------------------------------------------------------------------------
module sorted_alarm_timer_queue import satq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input logic        clk,
  input logic        rst,
  satq_in_if.sink    in_item,
  satq_out_if.source out_item
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  satq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_item.valid),
    .in_ready (in_item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  satq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_mode    (in_item.mode),
    .in_delay   (in_item.delay_seconds),
    .in_tag     (in_item.alarm_tag),
    .out_ready  (out_item.ready),
    .out_valid  (out_item.valid),
    .out_status (out_item.status),
    .out_tag    (out_item.fired_tag),
    .out_expiry (out_item.expiry_time),
    .out_now    (out_item.current_time),
    .out_last   (out_item.last)
  );

endmodule

>>> bench/tb_sorted_alarm_timer_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_alarm_timer_queue
// Self-checking bench for the sorted alarm timer queue. A directed table
// covers the corner cases: immediate fire, longest delay, equal expiry times,
// a full queue with reject, and ignored fields on ticks. Random ticks and
// inserts follow in four phases with different source and sink idling. An
// internal model of the sorted queue and seconds counter predicts every
// fired or rejected alarm, and each result is compared field by field.
// ----------------------------------------------------------------------------
module tb_sorted_alarm_timer_queue;
  import satq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PER_PHASE = 97;

  typedef struct packed {
    logic              status;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] expiry;
    logic [TIME_W-1:0] now_at;
    logic              last;
  } alarm_result_t;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_QUIET,
    CHK_SINGLE
  } row_check_t;

  typedef struct {
    logic               mode;
    logic [DELAY_W-1:0] delay;
    logic [TAG_W-1:0]   tag;
    row_check_t         check;
    alarm_result_t      want;
  } stim_row_t;

  logic clk;
  logic rst;

  satq_in_if  in_ch ();
  satq_out_if out_ch ();

  sorted_alarm_timer_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TAG_BITS   (TAG_W)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_item (in_ch),
    .out_item(out_ch)
  );

  logic [TIME_W-1:0] clock_now;
  logic [TIME_W-1:0] pending_expiry [QUEUE_DEPTH];
  logic [TAG_W-1:0]  pending_tag [QUEUE_DEPTH];
  int                pending_count;

  alarm_result_t expected_alarms[$];
  alarm_result_t head_alarm;
  stim_row_t     plan[$];

  int errors;
  int items_sent;
  int rejects;
  int results_seen;
  int idle_cycles;
  int send_gap_pct;
  int stall_pct;

  int gap_by_phase[4]    = '{0, 84, 0, 12};
  int stall_by_phase[4]  = '{0, 0, 84, 12};
  int insert_by_phase[4] = '{55, 60, 50, 65};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit is_after(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[TIME_W-1];
  endfunction

  function automatic void predict_alarms(input logic mode, input logic [DELAY_W-1:0] delay,
                                         input logic [TAG_W-1:0] tag, input bit record);
    alarm_result_t     batch[$];
    alarm_result_t     res;
    logic [TIME_W-1:0] due;
    int                slot;
    if (mode == MODE_TICK) begin
      clock_now = clock_now + TIME_W'(1);
    end else begin
      due = clock_now + {1'b0, delay};
      if (pending_count >= QUEUE_DEPTH) begin
        res = '{STATUS_REJECT, tag, due, clock_now, 1'b0};
        batch.push_back(res);
        rejects++;
      end else begin
        slot = 0;
        while (slot < pending_count && !is_after(pending_expiry[slot], due)) slot++;
        for (int i = pending_count; i > slot; i--) begin
          pending_expiry[i] = pending_expiry[i-1];
          pending_tag[i]    = pending_tag[i-1];
        end
        pending_expiry[slot] = due;
        pending_tag[slot]    = tag;
        pending_count++;
      end
    end
    while (pending_count > 0 && batch.size() < QUEUE_DEPTH &&
           !is_after(pending_expiry[0], clock_now)) begin
      res = '{STATUS_FIRED, pending_tag[0], pending_expiry[0], clock_now, 1'b0};
      batch.push_back(res);
      for (int i = 1; i < pending_count; i++) begin
        pending_expiry[i-1] = pending_expiry[i];
        pending_tag[i-1]    = pending_tag[i];
      end
      pending_count--;
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    if (record) begin
      foreach (batch[i]) expected_alarms.push_back(batch[i]);
    end
  endfunction

  function automatic void check_field(input string name, input logic [TIME_W-1:0] want,
                                      input logic [TIME_W-1:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, seen);
      errors++;
    end
  endfunction

  function automatic void add_row(input logic mode, input logic [DELAY_W-1:0] delay,
                                  input logic [TAG_W-1:0] tag, input row_check_t check,
                                  input alarm_result_t want);
    stim_row_t row;
    row.mode  = mode;
    row.delay = delay;
    row.tag   = tag;
    row.check = check;
    row.want  = want;
    plan.push_back(row);
  endfunction

  task automatic send_item(input logic mode, input logic [DELAY_W-1:0] delay,
                           input logic [TAG_W-1:0] tag, input bit record);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= mode;
    in_ch.delay_seconds <= delay;
    in_ch.alarm_tag     <= tag;
    do @(posedge clk); while (!in_ch.ready);
    predict_alarms(mode, delay, tag, record);
    items_sent++;
  endtask

  task automatic random_item(input int insert_pct);
    logic               mode;
    logic [DELAY_W-1:0] delay;
    int                 pick;
    mode = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_TICK;
    pick = $urandom_range(99);
    if (pick < 15) delay = '0;
    else if (pick < 97) delay = DELAY_W'($urandom_range(12));
    else delay = DELAY_W'($urandom);
    send_item(mode, delay, TAG_W'($urandom), 1'b1);
  endtask

  // hold the source until every predicted alarm has been seen
  task automatic hold_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_alarms.size() != 0) @(posedge clk);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_alarms.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d tag %h expiry %h",
                 $time, out_ch.status, out_ch.fired_tag, out_ch.expiry_time);
        errors++;
      end else begin
        head_alarm = expected_alarms.pop_front();
        check_field("status", TIME_W'(head_alarm.status), TIME_W'(out_ch.status));
        check_field("fired_tag", TIME_W'(head_alarm.tag), TIME_W'(out_ch.fired_tag));
        check_field("expiry_time", head_alarm.expiry, out_ch.expiry_time);
        check_field("current_time", head_alarm.now_at, out_ch.current_time);
        check_field("last", TIME_W'(head_alarm.last), TIME_W'(out_ch.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog: no handshake for %0d cycles", $time, idle_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst                 = 1'b1;
    in_ch.valid         = 1'b0;
    in_ch.mode          = MODE_TICK;
    in_ch.delay_seconds = '0;
    in_ch.alarm_tag     = '0;
    errors              = 0;
    items_sent          = 0;
    rejects             = 0;
    results_seen        = 0;
    idle_cycles         = 0;
    send_gap_pct        = 0;
    stall_pct           = 0;
    clock_now           = '0;
    pending_count       = 0;

    add_row(MODE_INSERT, '0, 16'hFFFF, CHK_SINGLE, '{STATUS_FIRED, 16'hFFFF, 32'd0, 32'd0, 1'b1});
    add_row(MODE_TICK, '0, '0, CHK_QUIET, '0);
    add_row(MODE_INSERT, 31'h7FFF_FFFF, 16'h0000, CHK_QUIET, '0);
    for (int i = 0; i < 14; i++) add_row(MODE_INSERT, 31'd3, TAG_W'(16'h0100 + i), CHK_MODEL, '0);
    add_row(MODE_INSERT, 31'd1, 16'h0200, CHK_MODEL, '0);
    add_row(MODE_INSERT, 31'd2, 16'hABCD, CHK_SINGLE,
            '{STATUS_REJECT, 16'hABCD, 32'd3, 32'd1, 1'b1});
    add_row(MODE_TICK, '0, '0, CHK_MODEL, '0);
    add_row(MODE_TICK, '0, '0, CHK_QUIET, '0);
    add_row(MODE_TICK, '0, '0, CHK_MODEL, '0);
    add_row(MODE_TICK, 31'h7FFF_FFFF, 16'hFFFF, CHK_QUIET, '0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      send_item(plan[i].mode, plan[i].delay, plan[i].tag, plan[i].check == CHK_MODEL);
      if (plan[i].check == CHK_SINGLE) expected_alarms.push_back(plan[i].want);
    end
    hold_until_drained();

    for (int p = 0; p < 4; p++) begin
      send_gap_pct = gap_by_phase[p];
      stall_pct    = stall_by_phase[p];
      repeat (RANDOM_PER_PHASE) random_item(insert_by_phase[p]);
      hold_until_drained();
    end

    repeat (40) @(posedge clk);
    if (expected_alarms.size() != 0) begin
      $display("%0t: %0d alarm results never arrived, first expected tag %h",
               $time, expected_alarms.size(), expected_alarms[0].tag);
      errors++;
    end

    $display("summary: %0d ticks and inserts sent, %0d inserts rejected on a full queue",
             items_sent, rejects);
    $display("summary: %0d alarm results checked across four source/sink idling phases",
             results_seen);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/satq_pkg.sv
rtl/satq_in_if.sv
rtl/satq_out_if.sv
rtl/satq_dp.sv
rtl/satq_ctrl.sv
rtl/sorted_alarm_timer_queue.sv
bench/tb_sorted_alarm_timer_queue.sv
